FILE: design/grid_ray_caster_column_unit_macros.svh
// ----------------------------------------------------------------------------
// Grid ray caster column unit - assertion macros
// Concurrent check wrappers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_CASTER_COLUMN_UNIT_MACROS_SVH
`define GRID_RAY_CASTER_COLUMN_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define GRCU_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// pre at one edge implies post at the next
`define GRCU_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define GRCU_ASSERT(name, cond, msg)
`define GRCU_ASSERT_NEXT(name, pre, post, msg)

`endif

`endif

FILE: design/grcu_pkg.sv
// ----------------------------------------------------------------------------
// Grid ray caster column unit - package
// Shared constants, FSM states and divider request/response types.
// ----------------------------------------------------------------------------
package grcu_pkg;

  localparam int MAP_SIZE_DEF = 32;
  localparam int TEX_SHIFT    = 6;     // texture width 64
  localparam int DIV_W        = 64;
  localparam int DIST_MAX     = 4194303;
  localparam int TOFF_MAX     = 65535;

  // config register indexes
  localparam logic [3:0] REG_POS_X    = 4'd0;
  localparam logic [3:0] REG_POS_Y    = 4'd1;
  localparam logic [3:0] REG_DIR_X    = 4'd2;
  localparam logic [3:0] REG_DIR_Y    = 4'd3;
  localparam logic [3:0] REG_PLANE_X  = 4'd4;
  localparam logic [3:0] REG_PLANE_Y  = 4'd5;
  localparam logic [3:0] REG_SCREEN_W = 4'd6;
  localparam logic [3:0] REG_SCREEN_H = 4'd7;

  // request kinds on tuser
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CAST  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CAM_DIV,
    S_RAY,
    S_INIT,
    S_STEP_MUL,
    S_STEP,
    S_TEST,
    S_DIST_DIV,
    S_V_MUL,
    S_V_ADD,
    S_MOD_DIV,
    S_TEX_DIV,
    S_L16_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

FILE: design/grid_ray_caster_column_unit.sv
// ----------------------------------------------------------------------------
// Grid ray caster column unit
// Holds a square wall map and casts one ray per request through it (DDA walk).
// ----------------------------------------------------------------------------
// channel   dir  handshake           content
// s_*       in   tvalid/tready       map write or column cast request
// m_*       out  tvalid/tready       one result per cast request
// cfg_*     in   cfg_valid/ready     register index and write data
//
// A cast with a hit runs up to five divisions on the shared bit-serial
// divider, setup and output states, and for each grid step a multiply, a
// step with map read and a test, up to 2*MAP_SIZE+2 steps.
// A cast that finds no wall skips the last four divisions.
// Map memory has no reset; cells must be written before a cast reads them.
// A finished result waits in the output register while the next request
// is taken; the unit stalls only if a second result is ready before then.
// ----------------------------------------------------------------------------
module grid_ray_caster_column_unit #(
  parameter int MAP_SIZE = grcu_pkg::MAP_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // column[10:0], cell_x[15:11], cell_y[20:16], cell_code[23:21]
  input  logic [0:0]  s_tuser,   // req_type[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // out_column, hit, hit_side, wall_code, wall_distance,
                                 // tex_u, line_height, start_row, tex_offset, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [20:0] cfg_data
);

  localparam int LIM   = 2 * MAP_SIZE + 2;
  localparam int NW    = $clog2(LIM + 1);
  localparam int SW    = 16 + $clog2(2 * MAP_SIZE + 4);
  localparam int CW    = $clog2(2 * MAP_SIZE + 40) + 1;
  localparam int DEPTH = MAP_SIZE * MAP_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = SW + 16;
  localparam int PW    = SW + 32;

  // config registers
  logic        [20:0] pos_x, pos_y;
  logic signed [17:0] dir_x, dir_y, plane_x, plane_y;
  logic        [11:0] screen_w, screen_h;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x    <= 21'd131072;
      pos_y    <= 21'd131072;
      dir_x    <= -18'sd65536;
      dir_y    <= '0;
      plane_x  <= '0;
      plane_y  <= -18'sd37837;
      screen_w <= 12'd1024;
      screen_h <= 12'd768;
    end else if (cfg_valid) begin
      case (cfg_index)
        grcu_pkg::REG_POS_X:    pos_x    <= cfg_data;
        grcu_pkg::REG_POS_Y:    pos_y    <= cfg_data;
        grcu_pkg::REG_DIR_X:    dir_x    <= cfg_data[17:0];
        grcu_pkg::REG_DIR_Y:    dir_y    <= cfg_data[17:0];
        grcu_pkg::REG_PLANE_X:  plane_x  <= cfg_data[17:0];
        grcu_pkg::REG_PLANE_Y:  plane_y  <= cfg_data[17:0];
        grcu_pkg::REG_SCREEN_W: screen_w <= cfg_data[11:0];
        grcu_pkg::REG_SCREEN_H: screen_h <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [10:0] in_column;
  logic [4:0]  in_cell_x, in_cell_y;
  logic [2:0]  in_cell_code;
  assign in_column    = s_tdata[10:0];
  assign in_cell_x    = s_tdata[15:11];
  assign in_cell_y    = s_tdata[20:16];
  assign in_cell_code = s_tdata[23:21];

  grcu_pkg::state_t state, state_next;
  grcu_pkg::div_req_t div_req;
  grcu_pkg::div_rsp_t div_rsp;

  grcu_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // datapath registers
  logic        [10:0]   col;
  logic signed [46:0]   prod_x, prod_y;
  logic signed [30:0]   rx, ry;
  logic        [SW-1:0] sx, sy, num;
  logic signed [CW-1:0] cx, cy;
  logic        [NW-1:0] n;
  logic                 side;
  logic        [SW+29:0] cmp_x, cmp_y;
  logic        [2:0]    rd_code, code;
  logic                 found;
  logic        [DW-1:0] hit_dist;
  logic        [50:0]   pa;
  logic signed [PW-1:0] pb;
  logic                 v_neg;
  logic        [5:0]    tex;
  logic        [44:0]   l16;
  logic        [2:0]    map_mem [DEPTH];

  logic        [29:0] arx, ary;
  assign arx = rx[30] ? 30'(-rx) : rx[29:0];
  assign ary = ry[30] ? 30'(-ry) : ry[29:0];

  logic        s_accept, cast_accept, map_we;
  logic [11:0] w_eff;
  logic        take_x, out_map, load_out;
  logic signed [CW-1:0] cx_n, cy_n;
  logic [AW-1:0] rd_addr, wr_addr;
  logic signed [28:0] cam;
  logic signed [57:0] v_sum;
  logic [57:0] v_mag;
  logic [45:0] m_val;
  logic [63:0] r_fix;

  assign s_tready    = state == grcu_pkg::S_IDLE;
  assign s_accept    = s_tvalid && s_tready;
  assign cast_accept = s_accept && s_tuser[0] == grcu_pkg::REQ_CAST;
  assign map_we      = s_accept && s_tuser[0] == grcu_pkg::REQ_WRITE
                       && 32'(in_cell_x) < 32'(MAP_SIZE) && 32'(in_cell_y) < 32'(MAP_SIZE);
  assign w_eff       = (screen_w == '0) ? 12'd1 : screen_w;
  assign cam         = $signed({1'b0, div_rsp.quot[27:0]}) - 29'sd65536;

  // DDA step; ties go to the y edge
  assign take_x  = (ry == '0) || (rx != '0 && cmp_x < cmp_y);
  assign cx_n    = take_x ? (rx[30] ? cx - 1'b1 : cx + 1'b1) : cx;
  assign cy_n    = take_x ? cy : (ry[30] ? cy - 1'b1 : cy + 1'b1);
  assign out_map = cx_n[CW-1] || cy_n[CW-1]
                   || cx_n >= $signed(CW'(MAP_SIZE)) || cy_n >= $signed(CW'(MAP_SIZE));
  assign rd_addr = AW'(cx_n) * AW'(MAP_SIZE) + AW'(cy_n);
  assign wr_addr = AW'(in_cell_x) * AW'(MAP_SIZE) + AW'(in_cell_y);

  assign v_sum = 58'(signed'({1'b0, pa})) + 58'(pb);
  assign v_mag = v_sum[57] ? 58'(-v_sum) : v_sum;
  assign m_val = side ? {ary, 16'b0} : {arx, 16'b0};
  assign r_fix = (v_neg && div_rsp.rem != '0) ? 64'(m_val) - div_rsp.rem : div_rsp.rem;

  // map memory, registered read
  always_ff @(posedge clk) begin
    if (map_we) map_mem[wr_addr] <= in_cell_code;
    rd_code <= map_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= grcu_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    load_out         = 1'b0;
    case (state)
      grcu_pkg::S_IDLE: begin
        if (cast_accept) begin
          div_req.start    = 1'b1;
          div_req.dividend = 64'(in_column) << 17;
          div_req.divisor  = 64'(w_eff);
          state_next       = grcu_pkg::S_CAM_DIV;
        end
      end
      grcu_pkg::S_CAM_DIV: if (div_rsp.done) state_next = grcu_pkg::S_RAY;
      grcu_pkg::S_RAY:      state_next = grcu_pkg::S_INIT;
      grcu_pkg::S_INIT: begin
        if (rx == '0 && ry == '0) state_next = grcu_pkg::S_OUT;
        else                      state_next = grcu_pkg::S_STEP_MUL;
      end
      grcu_pkg::S_STEP_MUL: state_next = grcu_pkg::S_STEP;
      grcu_pkg::S_STEP: begin
        if (out_map) state_next = grcu_pkg::S_OUT;
        else         state_next = grcu_pkg::S_TEST;
      end
      grcu_pkg::S_TEST: begin
        if (rd_code != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = 64'(num) << 16;
          div_req.divisor  = side ? 64'(ary) : 64'(arx);
          state_next       = grcu_pkg::S_DIST_DIV;
        end else if (n == NW'(LIM)) begin
          state_next = grcu_pkg::S_OUT;
        end else begin
          state_next = grcu_pkg::S_STEP_MUL;
        end
      end
      grcu_pkg::S_DIST_DIV: if (div_rsp.done) state_next = grcu_pkg::S_V_MUL;
      grcu_pkg::S_V_MUL:    state_next = grcu_pkg::S_V_ADD;
      grcu_pkg::S_V_ADD: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'(v_mag);
        div_req.divisor  = 64'(m_val);
        state_next       = grcu_pkg::S_MOD_DIV;
      end
      grcu_pkg::S_MOD_DIV: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = r_fix << grcu_pkg::TEX_SHIFT;
          div_req.divisor  = 64'(m_val);
          state_next       = grcu_pkg::S_TEX_DIV;
        end
      end
      grcu_pkg::S_TEX_DIV: begin
        if (div_rsp.done) begin
          if (hit_dist == '0) begin
            state_next = grcu_pkg::S_OUT;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = 64'(screen_h) << 32;
            div_req.divisor  = 64'(hit_dist);
            state_next       = grcu_pkg::S_L16_DIV;
          end
        end
      end
      grcu_pkg::S_L16_DIV: if (div_rsp.done) state_next = grcu_pkg::S_OUT;
      grcu_pkg::S_OUT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = grcu_pkg::S_IDLE;
        end
      end
      default: state_next = grcu_pkg::S_IDLE;
    endcase
  end

  // found flag is control
  always_ff @(posedge clk) begin
    if (rst) found <= 1'b0;
    else if (state == grcu_pkg::S_INIT) found <= 1'b0;
    else if (state == grcu_pkg::S_TEST && rd_code != '0) found <= 1'b1;
  end

  always_ff @(posedge clk) begin
    case (state)
      grcu_pkg::S_IDLE: if (cast_accept) col <= in_column;
      grcu_pkg::S_CAM_DIV: begin
        if (div_rsp.done) begin
          prod_x <= plane_x * cam;
          prod_y <= plane_y * cam;
        end
      end
      grcu_pkg::S_RAY: begin
        rx <= 31'(dir_x) + 31'(prod_x >>> 16);
        ry <= 31'(dir_y) + 31'(prod_y >>> 16);
      end
      grcu_pkg::S_INIT: begin
        cx <= CW'(pos_x[20:16]);
        cy <= CW'(pos_y[20:16]);
        sx <= (!rx[30] && rx != '0) ? SW'(17'h10000 - 17'(pos_x[15:0])) : SW'(pos_x[15:0]);
        sy <= (!ry[30] && ry != '0) ? SW'(17'h10000 - 17'(pos_y[15:0])) : SW'(pos_y[15:0]);
        n  <= '0;
      end
      grcu_pkg::S_STEP_MUL: begin
        cmp_x <= sx * ary;
        cmp_y <= sy * arx;
      end
      grcu_pkg::S_STEP: begin
        cx <= cx_n;
        cy <= cy_n;
        n  <= n + 1'b1;
        if (take_x) begin
          num  <= sx;
          sx   <= sx + SW'(32'h10000);
          side <= 1'b0;
        end else begin
          num  <= sy;
          sy   <= sy + SW'(32'h10000);
          side <= 1'b1;
        end
      end
      grcu_pkg::S_TEST: code <= rd_code;
      grcu_pkg::S_DIST_DIV: if (div_rsp.done) hit_dist <= div_rsp.quot[DW-1:0];
      grcu_pkg::S_V_MUL: begin
        pa <= side ? pos_x * ary : pos_y * arx;
        pb <= $signed({1'b0, num}) * (side ? rx : ry);
      end
      grcu_pkg::S_V_ADD: v_neg <= v_sum[57];
      grcu_pkg::S_TEX_DIV: begin
        if (div_rsp.done) begin
          tex <= div_rsp.quot[5:0];
          if (hit_dist == '0) l16 <= 45'h1 << 44;
        end
      end
      grcu_pkg::S_L16_DIV: if (div_rsp.done) l16 <= div_rsp.quot[44:0];
      default: ;
    endcase
  end

  // result fields
  logic [45:0] l16_up;
  logic [29:0] t_up;
  logic [27:0] h_q16;
  logic [27:0] d_start;
  logic [44:0] d_off;
  logic [27:0] off_q;
  logic [11:0] r_lh;
  logic [10:0] r_start;
  logic [15:0] r_off;
  logic [21:0] r_dist;

  assign l16_up  = 46'(l16) + 46'd65535;
  assign t_up    = l16_up[45:16];
  assign h_q16   = {screen_h, 16'b0};
  assign d_start = h_q16 - l16[27:0];
  assign d_off   = l16 - 45'(h_q16);
  assign off_q   = d_off[44:17];
  assign r_lh    = (t_up > 30'(screen_h)) ? screen_h : t_up[11:0];
  assign r_start = (45'(h_q16) > l16) ? d_start[27:17] : '0;
  assign r_off   = (l16 > 45'(h_q16))
                   ? ((off_q > 28'(grcu_pkg::TOFF_MAX)) ? 16'hFFFF : off_q[15:0]) : '0;
  assign r_dist  = (hit_dist > DW'(grcu_pkg::DIST_MAX))
                   ? 22'(grcu_pkg::DIST_MAX) : hit_dist[21:0];

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (load_out) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (found) m_tdata <= {5'b0, r_off, r_start, r_lh, tex, r_dist, code, side, 1'b1, col};
      else       m_tdata <= {77'b0, col};
    end
  end

  `include "grid_ray_caster_column_unit_macros.svh"

  `GRCU_ASSERT(a_div_no_restart, !(div_req.start && div_rsp.busy), "divider restarted while busy")
  `GRCU_ASSERT(a_test_in_map, state != grcu_pkg::S_TEST || (!cx[CW-1] && !cy[CW-1]), "cell test outside map")
  `GRCU_ASSERT(a_step_limit, state != grcu_pkg::S_STEP_MUL || n < NW'(LIM), "step limit passed")
  `GRCU_ASSERT_NEXT(a_out_load, load_out, m_tvalid, "result load lost")

endmodule

FILE: design/grcu_div.sv
// ----------------------------------------------------------------------------
// Grid ray caster column unit - divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grcu_div (
  input  logic              clk,
  input  logic              rst,
  input  grcu_pkg::div_req_t req,
  output grcu_pkg::div_rsp_t rsp
);

  localparam int W  = grcu_pkg::DIV_W;
  localparam int CNW = $clog2(W);

  logic [W-1:0]   quot;
  logic [W-1:0]   rem;
  logic [W-1:0]   dvsr;
  logic [CNW-1:0] cnt;
  logic           busy;
  logic           done;
  logic [W:0]     trial;
  logic           fits;

  assign trial = {rem, quot[W-1]};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNW'(W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.dividend;
      rem  <= '0;
      dvsr <= req.divisor;
      cnt  <= '0;
    end else if (busy) begin
      rem  <= fits ? W'(trial - {1'b0, dvsr}) : trial[W-1:0];
      quot <= {quot[W-2:0], fits};
      cnt  <= cnt + 1'b1;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule
